>>> rtl/sc2ch_pkg.sv
`timescale 1ns / 1ps

package sc2ch_pkg;

    // Scan code set 1 special bytes and key numbers (make code, bit 7 clear).
    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;

    // Character ranges used by the case adjustment.
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // Layouts that carry a table, and keys per table row.
    localparam int TABLE_COUNT = 3;
    localparam int KEY_ENTRIES = 58;
    localparam int KEY_IDX_W   = $clog2(KEY_ENTRIES);
    localparam int LAYOUT_W    = 2;

    // Status flags that travel beside each character.
    typedef struct packed {
        logic alt;
        logic ctrl;
        logic caps;
        logic shift;
    } t_mod_flags;

    typedef logic [7:0] t_key_row [KEY_ENTRIES];
    typedef t_key_row t_layout_tables [TABLE_COUNT][2];

    // Per layout: the unshifted row first, then the shifted row.
    localparam t_layout_tables KEY_TABLE = '{
        '{  // US
            '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
              8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h20, 8'h71, 8'h77, 8'h65, 8'h72,
              8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
              8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
              8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
              8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20},
            '{8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
              8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
              8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
              8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
              8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
              8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20}
        },
        '{  // ES
            '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
              8'h39, 8'h30, 8'h27, 8'h21, 8'h08, 8'h20, 8'h71, 8'h77, 8'h65, 8'h72,
              8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00,
              8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6E,
              8'hAC, 8'h00, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
              8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20},
            '{8'h00, 8'h00, 8'h22, 8'h27, 8'h2E, 8'h35, 8'h00, 8'h37, 8'h38, 8'h39,
              8'h30, 8'h27, 8'h3F, 8'h21, 8'h08, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
              8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00,
              8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4E,
              8'hBF, 8'h60, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
              8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20}
        },
        '{  // DE
            '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
              8'h39, 8'h30, 8'hDF, 8'hB4, 8'h08, 8'h20, 8'h71, 8'h77, 8'h65, 8'h72,
              8'h74, 8'h7A, 8'h75, 8'h69, 8'h6F, 8'h70, 8'hFC, 8'h2B, 8'h0A, 8'h00,
              8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF6,
              8'hE4, 8'h5E, 8'h00, 8'h5C, 8'h79, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
              8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20},
            '{8'h00, 8'h00, 8'h21, 8'h22, 8'hA7, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
              8'h29, 8'h3D, 8'h3F, 8'h60, 8'h08, 8'h20, 8'h51, 8'h57, 8'h45, 8'h52,
              8'h54, 8'h5A, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hDC, 8'h2A, 8'h0A, 8'h00,
              8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hD6,
              8'hC4, 8'hB0, 8'h00, 8'hDF, 8'h59, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
              8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20}
        }
    };

endpackage

>>> rtl/scancode_to_char_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] = scan_byte
// m_axis    out        tdata[7:0] = char_code, tuser[3:0] = shift, caps, ctrl, alt
// cfg       in         data[1:0]  = layout_select
//
// One scan byte per cycle is accepted while s_axis_tready is high. The input register
// takes the byte on transfer and the result register takes its decode when the decode
// stage advances; the result is then offered on m_axis until the character side takes it.
// Reset (synchronous, active low) clears all modifier flags, the prefix flag,
// both valid bits and selects the US layout.
// A stalled result holds in the result register while the input register still
// takes one more byte; s_axis_tready drops only when both are full and the
// character side stalls.
module scancode_to_char_decoder_top #(
    parameter int NUM_LAYOUTS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Scan byte stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] scan_byte
    // Character stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_code
    output logic [3:0] o_m_axis_tuser,   // [0] shift_held, [1] caps_on, [2] ctrl_held,
                                         // [3] alt_held
    // Layout select register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [sc2ch_pkg::LAYOUT_W-1:0] i_cfg_data  // [1:0] layout_select
);
    import sc2ch_pkg::*;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    t_mod_flags          r_out_mods;
    t_mod_flags          r_mods;
    logic                r_prefix;
    logic [LAYOUT_W-1:0] r_layout;

    t_mod_flags          n_mods;
    logic                n_prefix;
    logic [7:0]          n_char;
    logic [7:0]          lookup_char;
    logic [6:0]          key;
    logic                advance;

    // The decode stage moves on whenever the result register is free or drains.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tuser  = r_out_mods;

    assign key = r_in_byte[6:0];

    // Table lookup with the current shift state, then the caps/shift case rule.
    always_comb begin
        lookup_char = 8'h00;
        if ((int'(r_layout) < TABLE_COUNT) && (int'(key) < KEY_ENTRIES)) begin
            lookup_char = KEY_TABLE[r_layout][r_mods.shift][key[KEY_IDX_W-1:0]];
        end
        if ((lookup_char >= CH_LOWER_A) && (lookup_char <= CH_LOWER_Z)) begin
            if (r_mods.caps != r_mods.shift) begin
                lookup_char = lookup_char - CH_CASE;
            end
        end else if ((lookup_char >= CH_UPPER_A) && (lookup_char <= CH_UPPER_Z)) begin
            if (r_mods.caps && !r_mods.shift) begin
                lookup_char = lookup_char + CH_CASE;
            end
        end
    end

    // Prefix, break and modifier handling for the byte in the input register.
    always_comb begin
        n_mods   = r_mods;
        n_prefix = r_prefix;
        n_char   = 8'h00;
        if (r_in_byte == SC_PREFIX) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
        end else if (r_in_byte[7]) begin
            case (key) inside
                KEY_LSHIFT, KEY_RSHIFT: n_mods.shift = 1'b0;
                KEY_CTRL:               n_mods.ctrl  = 1'b0;
                KEY_ALT:                n_mods.alt   = 1'b0;
                default:                n_mods       = r_mods;
            endcase
        end else begin
            case (key) inside
                KEY_LSHIFT, KEY_RSHIFT: n_mods.shift = 1'b1;
                KEY_CAPS:               n_mods.caps  = !r_mods.caps;
                KEY_CTRL:               n_mods.ctrl  = 1'b1;
                KEY_ALT:                n_mods.alt   = 1'b1;
                default:                n_char       = lookup_char;
            endcase
        end
    end

    // Control state: valid bits, decoder flags and the layout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mods      <= '0;
            r_prefix    <= 1'b0;
            r_layout    <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mods      <= n_mods;
                r_prefix    <= n_prefix;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && (int'(i_cfg_data) < NUM_LAYOUTS)) begin
                r_layout <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out_char <= n_char;
            r_out_mods <= n_mods;
        end
    end

`ifndef SYNTH
    // A prefix byte leaves the prefix flag armed.
    a_prefix_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_byte == SC_PREFIX)) |=> r_prefix)
        else $error("prefix flag not set after prefix byte");

    // A prefix byte or a prefixed code never yields a character.
    a_prefix_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && ((r_in_byte == SC_PREFIX) || r_prefix)) |-> (n_char == 8'h00))
        else $error("character produced for prefixed code");

    // The input side stalls only when both registers hold data and the sink stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without cause");

    // An unprefixed caps make code flips caps lock.
    a_caps_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_prefix && (r_in_byte == {1'b0, KEY_CAPS}))
        |=> (r_mods.caps != $past(r_mods.caps)))
        else $error("caps lock did not toggle");
`endif

endmodule
